// ===== src/cartesian_neighbor_rank_macros.svh =====
// assertion macros shared by the cartesian neighbor rank rtl
// expects signals named clock and reset in the scope of each use
`ifndef CARTESIAN_NEIGHBOR_RANK_MACROS_SVH
`define CARTESIAN_NEIGHBOR_RANK_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define CNR_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cnr check failed");
// next-cycle implication
`define CNR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cnr check failed");
// implication after a fixed number of cycles
`define CNR_ASSERT_DELAY(lbl, ante, dly, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##(dly) (cons)) \
      else $error("cnr check failed");
`else
`define CNR_ASSERT_IMPL(lbl, ante, cons)
`define CNR_ASSERT_NEXT(lbl, ante, cons)
`define CNR_ASSERT_DELAY(lbl, ante, dly, cons)
`endif
`endif

// ===== src/cnr_pkg.sv =====
// shared types and constants of the cartesian neighbor rank block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cnr_pkg;

   localparam int RANK_W     = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int ND_W       = 4;
   localparam int NUM_DIMS_W = 3;
   localparam int PMASK_W    = 4;

   // csr register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_DIMS      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIM_SIZES     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIODIC_MASK = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_RANK      = 3'd3;

   localparam logic [NUM_DIMS_W-1:0] NUM_DIMS_RESET  = 3'd1;
   localparam logic [RANK_W-1:0]     DIM_SIZES_RESET = 32'h0101_0101;

   // response status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NULL    = 2'd1;
   localparam logic [1:0] STATUS_BAD_DIR = 2'd2;

   typedef struct packed {
      logic [2:0]         direction;
      logic signed [15:0] displacement;
   } req_type;

   typedef struct packed {
      logic [RANK_W-1:0] neighbor_rank;
      logic [1:0]        status;
   } rsp_type;

   // control that travels with each pipeline slot
   typedef struct packed {
      logic       valid;
      logic [1:0] status;
   } ctl_type;

   // rank terms carried alongside the modulo pipeline
   typedef struct packed {
      logic [RANK_W-1:0] part;
      logic [RANK_W-1:0] stride;
   } side_type;

endpackage

`default_nettype wire

// ===== src/cnr_prep.sv =====
// csr registers and serial mixed-radix split of own_rank into coordinates
// depends on cnr_pkg
`timescale 1ns / 1ps
`default_nettype none

module cnr_prep import cnr_pkg::*; #(
   parameter int MAX_DIMS = 4,
   parameter int DIM_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [CSR_IDX_W-1:0]                  csr_index,
   input  logic [CSR_DATA_W-1:0]                 csr_data,
   output logic                                  busy,
   output logic [ND_W-1:0]                       num_dims_eff,
   output logic [MAX_DIMS-1:0]                   periodic,
   output logic [MAX_DIMS-1:0][DIM_BITS-1:0]     sizes,
   output logic [MAX_DIMS-1:0][DIM_BITS-1:0]     coords,
   output logic [MAX_DIMS-1:0][RANK_W-1:0]       strides,
   output logic [RANK_W-1:0]                     base
);

   localparam int DIDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int BIT_W  = $clog2(RANK_W);

   typedef enum logic [1:0] {ST_START, ST_DIV, ST_ACC, ST_IDLE} state_type;

   state_type                            state_in, state_ff;
   logic [NUM_DIMS_W-1:0]                num_dims_in, num_dims_ff;
   logic [RANK_W-1:0]                    dim_sizes_in, dim_sizes_ff;
   logic [PMASK_W-1:0]                   periodic_mask_in, periodic_mask_ff;
   logic [RANK_W-1:0]                    own_rank_in, own_rank_ff;
   logic [RANK_W-1:0]                    q_in, q_ff;
   logic [DIM_BITS-1:0]                  rem_in, rem_ff;
   logic [BIT_W-1:0]                     bit_in, bit_ff;
   logic [DIDX_W-1:0]                    dim_in, dim_ff;
   logic [RANK_W-1:0]                    stride_acc_in, stride_acc_ff;
   logic [RANK_W-1:0]                    base_in, base_ff;
   logic [MAX_DIMS-1:0][DIM_BITS-1:0]    coords_in, coords_ff;
   logic [MAX_DIMS-1:0][RANK_W-1:0]      strides_in, strides_ff;

   logic                                 csr_write;
   logic [DIM_BITS-1:0]                  cur_size;
   logic [DIM_BITS:0]                    rem_shift;
   logic                                 rem_ge;
   logic [DIM_BITS:0]                    rem_sub;
   logic [RANK_W+DIM_BITS-1:0]           acc_prod;
   logic [RANK_W+DIM_BITS-1:0]           stride_prod;
   logic                                 dim_in_use;

   // packed sizes, a zero field or one past the register reads as size one
   for (genvar d = 0; d < MAX_DIMS; d++) begin : g_size
      logic [2*RANK_W-1:0] size_ext;
      assign size_ext = {{RANK_W{1'b0}}, dim_sizes_ff} >> (d * DIM_BITS);
      assign sizes[d] = (size_ext[DIM_BITS-1:0] == '0) ? DIM_BITS'(1)
                                                       : size_ext[DIM_BITS-1:0];
      if (d < PMASK_W) begin : g_per
         assign periodic[d] = periodic_mask_ff[d];
      end else begin : g_noper
         assign periodic[d] = 1'b0;
      end
   end

   assign csr_ready    = 1'b1;
   assign csr_write    = csr_valid && csr_ready;
   assign busy         = (state_ff != ST_IDLE);
   assign num_dims_eff = (ND_W'(num_dims_ff) > ND_W'(MAX_DIMS)) ? ND_W'(MAX_DIMS)
                                                                : ND_W'(num_dims_ff);
   assign coords       = coords_ff;
   assign strides      = strides_ff;
   assign base         = base_ff;

   // one restoring divide step per cycle
   assign cur_size    = sizes[dim_ff];
   assign rem_shift   = {rem_ff, q_ff[RANK_W-1]};
   assign rem_ge      = (rem_shift >= {1'b0, cur_size});
   assign rem_sub     = rem_ge ? (rem_shift - {1'b0, cur_size}) : rem_shift;
   assign acc_prod    = rem_ff * stride_acc_ff;
   assign stride_prod = stride_acc_ff * cur_size;
   assign dim_in_use  = (ND_W'(dim_ff) < num_dims_eff);

   always_comb begin
      state_in         = state_ff;
      num_dims_in      = num_dims_ff;
      dim_sizes_in     = dim_sizes_ff;
      periodic_mask_in = periodic_mask_ff;
      own_rank_in      = own_rank_ff;
      q_in             = q_ff;
      rem_in           = rem_ff;
      bit_in           = bit_ff;
      dim_in           = dim_ff;
      stride_acc_in    = stride_acc_ff;
      base_in          = base_ff;
      coords_in        = coords_ff;
      strides_in       = strides_ff;

      unique case (state_ff)
         ST_START: begin
            q_in          = own_rank_ff;
            rem_in        = '0;
            bit_in        = '0;
            dim_in        = '0;
            stride_acc_in = RANK_W'(1);
            base_in       = '0;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            q_in   = {q_ff[RANK_W-2:0], rem_ge};
            rem_in = rem_sub[DIM_BITS-1:0];
            bit_in = bit_ff + BIT_W'(1);
            if (bit_ff == BIT_W'(RANK_W - 1)) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            coords_in[dim_ff]  = rem_ff;
            strides_in[dim_ff] = stride_acc_ff;
            if (dim_in_use) begin
               base_in = base_ff + acc_prod[RANK_W-1:0];
            end
            stride_acc_in = stride_prod[RANK_W-1:0];
            rem_in        = '0;
            if (dim_ff == DIDX_W'(MAX_DIMS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               dim_in   = dim_ff + DIDX_W'(1);
               state_in = ST_DIV;
            end
         end
         ST_IDLE: begin
         end
      endcase

      // any csr write reruns the split
      if (csr_write) begin
         state_in = ST_START;
         unique case (csr_index)
            CSR_NUM_DIMS:      num_dims_in      = csr_data[NUM_DIMS_W-1:0];
            CSR_DIM_SIZES:     dim_sizes_in     = csr_data[RANK_W-1:0];
            CSR_PERIODIC_MASK: periodic_mask_in = csr_data[PMASK_W-1:0];
            CSR_OWN_RANK:      own_rank_in      = csr_data[RANK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      q_ff          <= q_in;
      rem_ff        <= rem_in;
      bit_ff        <= bit_in;
      dim_ff        <= dim_in;
      stride_acc_ff <= stride_acc_in;
      base_ff       <= base_in;
      coords_ff     <= coords_in;
      strides_ff    <= strides_in;
      if (reset) begin
         state_ff         <= ST_START;
         num_dims_ff      <= NUM_DIMS_RESET;
         dim_sizes_ff     <= DIM_SIZES_RESET;
         periodic_mask_ff <= '0;
         own_rank_ff      <= '0;
      end else begin
         state_ff         <= state_in;
         num_dims_ff      <= num_dims_in;
         dim_sizes_ff     <= dim_sizes_in;
         periodic_mask_ff <= periodic_mask_in;
         own_rank_ff      <= own_rank_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/cnr_mod.sv =====
// pipelined remainder of a magnitude by a dimension size, one bit per stage
// depends on cnr_pkg
`timescale 1ns / 1ps
`default_nettype none

module cnr_mod import cnr_pkg::*; #(
   parameter int DIM_BITS = 8,
   parameter int MAG_W    = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  ctl_type             in_ctl,
   input  side_type            in_side,
   input  logic [MAG_W-1:0]    in_mag,
   input  logic                in_neg,
   input  logic [DIM_BITS-1:0] in_size,
   output ctl_type             out_ctl,
   output side_type            out_side,
   output logic                out_neg,
   output logic [DIM_BITS-1:0] out_size,
   output logic [DIM_BITS-1:0] out_rem
);

   localparam int WIDE_W = MAG_W + DIM_BITS;

   typedef struct packed {
      side_type            side;
      logic                neg;
      logic [DIM_BITS-1:0] size;
      logic [MAG_W-1:0]    rem;
   } lane_type;

   ctl_type  ctl_in  [MAG_W];
   ctl_type  ctl_ff  [MAG_W];
   lane_type lane_in [MAG_W];
   lane_type lane_ff [MAG_W];

   for (genvar j = 0; j < MAG_W; j++) begin : g_stage
      localparam int SHIFT = MAG_W - 1 - j;
      ctl_type           ctl_prev;
      lane_type          lane_prev;
      logic [WIDE_W-1:0] rem_wide;
      logic [WIDE_W-1:0] sub_wide;
      logic [WIDE_W-1:0] diff_wide;

      if (j == 0) begin : g_first
         assign ctl_prev  = in_ctl;
         assign lane_prev = {in_side, in_neg, in_size, in_mag};
      end else begin : g_next
         assign ctl_prev  = ctl_ff[j-1];
         assign lane_prev = lane_ff[j-1];
      end

      // remove size << SHIFT when it fits
      assign sub_wide   = WIDE_W'(lane_prev.size) << SHIFT;
      assign rem_wide   = WIDE_W'(lane_prev.rem);
      assign diff_wide  = rem_wide - sub_wide;
      assign ctl_in[j]  = ctl_prev;
      assign lane_in[j] = (rem_wide >= sub_wide)
                        ? {lane_prev.side, lane_prev.neg, lane_prev.size, diff_wide[MAG_W-1:0]}
                        : lane_prev;

      always_ff @(posedge clock) begin
         lane_ff[j] <= lane_in[j];
         if (reset) begin
            ctl_ff[j] <= '0;
         end else begin
            ctl_ff[j] <= ctl_in[j];
         end
      end
   end

   assign out_ctl  = ctl_ff[MAG_W-1];
   assign out_side = lane_ff[MAG_W-1].side;
   assign out_neg  = lane_ff[MAG_W-1].neg;
   assign out_size = lane_ff[MAG_W-1].size;
   assign out_rem  = lane_ff[MAG_W-1].rem[DIM_BITS-1:0];

endmodule

`default_nettype wire

// ===== src/cartesian_neighbor_rank.sv =====
// cartesian_neighbor_rank top level; uses cnr_pkg, cnr_prep, cnr_mod and the macros header
// registers from start to rsp_valid: s1, s2, the cnr_mod stages, p1, p2 and rsp; MAG_W = max(15, DIM_BITS) + 1
// throughput: one transaction per cycle while busy is low; nothing stalls, the receiver takes each result as shown
// after reset and after every csr write, busy is high while the serial divider in cnr_prep splits own_rank
// reset: synchronous, active high; clears pipeline valids and restores csr defaults
`timescale 1ns / 1ps
`default_nettype none
`include "cartesian_neighbor_rank_macros.svh"

module cartesian_neighbor_rank import cnr_pkg::*; #(
   parameter int MAX_DIMS = 4,
   parameter int DIM_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req,
   output logic                  rsp_valid,
   output rsp_type               rsp,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // magnitude of coordinate plus displacement, and its signed width
   localparam int MAG_W   = ((DIM_BITS > 15) ? DIM_BITS : 15) + 1;
   localparam int C_W     = MAG_W + 1;
   localparam int LATENCY = MAG_W + 5;

   // stage 1: operands picked for the requested direction
   typedef struct packed {
      logic [15:0]         dis;
      logic [DIM_BITS-1:0] coord;
      logic [DIM_BITS-1:0] size;
      logic [RANK_W-1:0]   stride;
      logic                per;
   } s1_type;

   // stage 2: shifted coordinate split into sign and magnitude
   typedef struct packed {
      logic [MAG_W-1:0]    mag;
      logic                neg;
      logic [DIM_BITS-1:0] size;
      logic [RANK_W-1:0]   stride;
      logic [RANK_W-1:0]   prod;
   } s2_type;

   // post-modulo stages
   typedef struct packed {
      logic [DIM_BITS-1:0] newc;
      side_type            side;
   } p1_type;

   typedef struct packed {
      logic [RANK_W-1:0] part;
      logic [RANK_W-1:0] prod;
   } p2_type;

   // derived configuration from the prep unit
   logic [ND_W-1:0]                   num_dims_eff;
   logic [MAX_DIMS-1:0]               periodic;
   logic [MAX_DIMS-1:0][DIM_BITS-1:0] sizes;
   logic [MAX_DIMS-1:0][DIM_BITS-1:0] coords;
   logic [MAX_DIMS-1:0][RANK_W-1:0]   strides;
   logic [RANK_W-1:0]                 base;

   ctl_type s1_ctl_in, s1_ctl_ff;
   s1_type  s1_in, s1_ff;
   ctl_type s2_ctl_in, s2_ctl_ff;
   s2_type  s2_in, s2_ff;
   ctl_type p1_ctl_in, p1_ctl_ff;
   p1_type  p1_in, p1_ff;
   ctl_type p2_ctl_in, p2_ctl_ff;
   p2_type  p2_in, p2_ff;
   logic    rsp_valid_in, rsp_valid_ff;
   rsp_type rsp_in, rsp_ff;

   logic                       accept;
   logic                       dir_bad;
   logic signed [C_W-1:0]      c_sum;
   logic                       c_neg;
   logic                       c_over;
   logic [C_W-1:0]             c_neg_val;
   logic [RANK_W+DIM_BITS-1:0] old_prod;
   logic [RANK_W+DIM_BITS-1:0] new_prod;

   side_type                   mod_side_in;
   ctl_type                    mod_ctl;
   side_type                   mod_side;
   logic                       mod_neg;
   logic [DIM_BITS-1:0]        mod_size;
   logic [DIM_BITS-1:0]        mod_rem;

   // csr registers plus the own-rank split into coordinates, strides and base rank
   cnr_prep #(
      .MAX_DIMS (MAX_DIMS),
      .DIM_BITS (DIM_BITS)
   ) u_prep (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .busy         (busy),
      .num_dims_eff (num_dims_eff),
      .periodic     (periodic),
      .sizes        (sizes),
      .coords       (coords),
      .strides      (strides),
      .base         (base)
   );

   // stage 1: take the transaction and pick per-direction operands
   assign accept  = start && !busy;
   assign dir_bad = (ND_W'(req.direction) >= num_dims_eff);

   always_comb begin
      s1_in.dis    = req.displacement;
      s1_in.coord  = '0;
      s1_in.size   = DIM_BITS'(1);
      s1_in.stride = '0;
      s1_in.per    = 1'b0;
      for (int d = 0; d < MAX_DIMS; d++) begin
         if (req.direction == 3'(d)) begin
            s1_in.coord  = coords[d];
            s1_in.size   = sizes[d];
            s1_in.stride = strides[d];
            s1_in.per    = periodic[d];
         end
      end
      s1_ctl_in.valid  = accept;
      s1_ctl_in.status = dir_bad ? STATUS_BAD_DIR : STATUS_OK;
   end

   // stage 2: add the displacement, check the edges, and start removing the old term
   assign c_sum     = $signed({{(C_W-DIM_BITS){1'b0}}, s1_ff.coord})
                    + C_W'($signed(s1_ff.dis));
   assign c_neg     = c_sum[C_W-1];
   assign c_over    = ($unsigned(c_sum) >= C_W'(s1_ff.size));
   assign c_neg_val = -c_sum;
   assign old_prod  = s1_ff.coord * s1_ff.stride;

   always_comb begin
      s2_in.mag    = c_neg ? c_neg_val[MAG_W-1:0] : c_sum[MAG_W-1:0];
      s2_in.neg    = c_neg;
      s2_in.size   = s1_ff.size;
      s2_in.stride = s1_ff.stride;
      s2_in.prod   = old_prod[RANK_W-1:0];
      s2_ctl_in    = s1_ctl_ff;
      // off an edge of a dimension that does not wrap
      if (s1_ctl_ff.status == STATUS_OK && (c_neg || c_over) && !s1_ff.per) begin
         s2_ctl_in.status = STATUS_NULL;
      end
   end

   // base rank without the old coordinate's term rides next to the remainder
   assign mod_side_in.part   = base - s2_ff.prod;
   assign mod_side_in.stride = s2_ff.stride;

   cnr_mod #(
      .DIM_BITS (DIM_BITS),
      .MAG_W    (MAG_W)
   ) u_mod (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (s2_ctl_ff),
      .in_side  (mod_side_in),
      .in_mag   (s2_ff.mag),
      .in_neg   (s2_ff.neg),
      .in_size  (s2_ff.size),
      .out_ctl  (mod_ctl),
      .out_side (mod_side),
      .out_neg  (mod_neg),
      .out_size (mod_size),
      .out_rem  (mod_rem)
   );

   // true modulo: a negative value with nonzero remainder folds to size - remainder
   always_comb begin
      p1_ctl_in  = mod_ctl;
      p1_in.side = mod_side;
      p1_in.newc = (mod_neg && mod_rem != '0) ? (mod_size - mod_rem) : mod_rem;
   end

   // new coordinate's term
   assign new_prod = p1_ff.newc * p1_ff.side.stride;

   always_comb begin
      p2_ctl_in  = p1_ctl_ff;
      p2_in.part = p1_ff.side.part;
      p2_in.prod = new_prod[RANK_W-1:0];
   end

   // result register, rank forced to zero on null or bad direction
   always_comb begin
      rsp_valid_in         = p2_ctl_ff.valid;
      rsp_in.status        = p2_ctl_ff.status;
      rsp_in.neighbor_rank = (p2_ctl_ff.status == STATUS_OK) ? (p2_ff.part + p2_ff.prod)
                                                               : '0;
   end

   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      s2_ff  <= s2_in;
      p1_ff  <= p1_in;
      p2_ff  <= p2_in;
      rsp_ff <= rsp_in;
      s1_ctl_ff.status <= s1_ctl_in.status;
      s2_ctl_ff.status <= s2_ctl_in.status;
      p1_ctl_ff.status <= p1_ctl_in.status;
      p2_ctl_ff.status <= p2_ctl_in.status;
      if (reset) begin
         s1_ctl_ff.valid <= 1'b0;
         s2_ctl_ff.valid <= 1'b0;
         p1_ctl_ff.valid <= 1'b0;
         p2_ctl_ff.valid <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         s1_ctl_ff.valid <= s1_ctl_in.valid;
         s2_ctl_ff.valid <= s2_ctl_in.valid;
         p1_ctl_ff.valid <= p1_ctl_in.valid;
         p2_ctl_ff.valid <= p2_ctl_in.valid;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // every accepted transaction comes out after the fixed pipeline latency
   `CNR_ASSERT_DELAY(a_fixed_latency, start && !busy, LATENCY, rsp_valid)
   // null and bad-direction results carry a zero rank
   `CNR_ASSERT_IMPL(a_rank_zero_on_error, rsp_valid && rsp.status != STATUS_OK, rsp.neighbor_rank == '0)
   // a csr write holds off new transactions while the split reruns
   `CNR_ASSERT_NEXT(a_csr_write_busy, csr_valid && csr_ready, busy)
   // only defined status codes leave the block
   `CNR_ASSERT_IMPL(a_status_defined, rsp_valid, rsp.status == STATUS_OK || rsp.status == STATUS_NULL || rsp.status == STATUS_BAD_DIR)

endmodule

`default_nettype wire
